// ===== rtl/core/dhcp_client_handshake_macros.svh =====
// Assertion helpers for the RTL files of the DHCP client block; only the handshake controller includes them.
`ifndef DHCP_CLIENT_HANDSHAKE_MACROS_SVH
`define DHCP_CLIENT_HANDSHAKE_MACROS_SVH

`ifndef SYNTHESIS

`define DHCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhcp assertion failed");

`define DHCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhcp assertion failed");

`else

`define DHCP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define DHCP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/dhcp_pkg.sv =====
`default_nettype none
package dhcp_pkg;

  localparam int unsigned MAX_FRAME = 1536;
  localparam int unsigned FPOS_W = 11;
  localparam logic [FPOS_W-1:0] OPT_START = 11'd282;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_BYTE = 2'd2;

  localparam logic [1:0] EV_DISCOVER = 2'd0;
  localparam logic [1:0] EV_REQUEST = 2'd1;
  localparam logic [1:0] EV_BOUND = 2'd2;
  localparam logic [1:0] EV_FAILED = 2'd3;

  localparam logic [7:0] ETH_TYPE_HI = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO = 8'h00;
  localparam logic [7:0] IP_PROTO_UDP = 8'd17;
  localparam logic [7:0] UDP_PORT_HI = 8'd0;
  localparam logic [7:0] UDP_PORT_LO = 8'd68;
  localparam logic [7:0] XID_HI = 8'hAA;
  localparam logic [7:0] XID_LO = 8'h33;

  localparam logic [7:0] OPT_END = 8'd255;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK = 8'd5;

  localparam logic [31:0] TICKS_RESET = 32'd1000;
  localparam logic [3:0] ATTEMPTS_RESET = 4'd3;

  localparam int unsigned RES_DEPTH = 3;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_LVL_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DISC  = 2'd1,
    PH_OFFER = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] ip_addr;
    logic [31:0] server_addr;
  } res_t;

  typedef struct packed {
    logic        eof;
    logic        ok;
    logic [7:0]  msg_type;
    logic [31:0] your_addr;
    logic [31:0] server_id;
  } frame_info_t;

endpackage
`default_nettype wire

// ===== rtl/core/dhcp_parser.sv =====
`default_nettype none
module dhcp_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 byte_en,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 rx_last,
  output dhcp_pkg::frame_info_t     info
);
  import dhcp_pkg::*;

  logic [FPOS_W-1:0] pos_r, pos_nxt;
  logic              ok_r, ok_nxt;
  logic [7:0]        msg_r, msg_nxt;
  logic [31:0]       sid_r, sid_nxt;
  logic [31:0]       ya_r, ya_nxt;
  logic [FPOS_W-1:0] nopt_r, nopt_nxt;
  logic [7:0]        code_r, code_nxt;
  logic [7:0]        len_r, len_nxt;
  logic              stop_r, stop_nxt;
  logic [31:0]       gather_r, gather_nxt;

  logic              take;
  logic              eof;
  logic [FPOS_W-1:0] off;
  logic [FPOS_W-1:0] pos_inc;
  logic [1:0]        lane;
  logic [1:0]        vi;
  logic [31:0]       gw;

  assign take = byte_en && (pos_r < FPOS_W'(MAX_FRAME));
  assign eof = byte_en && rx_last;
  assign off = pos_r - nopt_r;
  assign pos_inc = pos_r + 11'd1;
  assign lane = 2'(pos_r[1:0] - 2'd2);
  assign vi = 2'(off - 11'd2);
  assign gw = gather_r | ({24'b0, rx_byte} << {vi, 3'b000});

  always_comb begin
    pos_nxt = pos_r;
    ok_nxt = ok_r;
    msg_nxt = msg_r;
    sid_nxt = sid_r;
    ya_nxt = ya_r;
    nopt_nxt = nopt_r;
    code_nxt = code_r;
    len_nxt = len_r;
    stop_nxt = stop_r;
    gather_nxt = gather_r;
    if (take) begin
      pos_nxt = pos_inc;
      case (pos_r)
        11'd12: if (rx_byte != ETH_TYPE_HI) ok_nxt = 1'b0;
        11'd13: if (rx_byte != ETH_TYPE_LO) ok_nxt = 1'b0;
        11'd23: if (rx_byte != IP_PROTO_UDP) ok_nxt = 1'b0;
        11'd36: if (rx_byte != UDP_PORT_HI) ok_nxt = 1'b0;
        11'd37: if (rx_byte != UDP_PORT_LO) ok_nxt = 1'b0;
        11'd46: if (rx_byte != XID_HI) ok_nxt = 1'b0;
        11'd47: if (rx_byte != XID_LO) ok_nxt = 1'b0;
        default: ;
      endcase
      if (pos_r >= 11'd58 && pos_r <= 11'd61) begin
        ya_nxt = ya_r | ({24'b0, rx_byte} << {lane, 3'b000});
      end
      if (!stop_r && pos_r >= nopt_r) begin
        if (off == 11'd0) begin
          if (rx_byte == OPT_END) begin
            stop_nxt = 1'b1;
          end else begin
            code_nxt = rx_byte;
          end
        end else if (off == 11'd1) begin
          len_nxt = rx_byte;
          gather_nxt = 32'd0;
          if (rx_byte == 8'd0) nopt_nxt = pos_inc;
        end else begin
          if (code_r == OPT_MSG_TYPE && len_r == 8'd1) msg_nxt = rx_byte;
          if (code_r == OPT_SERVER_ID && len_r == 8'd4 && off <= 11'd5) begin
            gather_nxt = gw;
            if (vi == 2'd3) sid_nxt = gw;
          end
          if (off == {3'b000, len_r} + 11'd1) nopt_nxt = pos_inc;
        end
      end
    end
  end

  assign info.eof = eof;
  assign info.ok = ok_nxt && (pos_nxt >= OPT_START);
  assign info.msg_type = msg_nxt;
  assign info.your_addr = ya_nxt;
  assign info.server_id = sid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || eof) begin
      pos_r <= '0;
      ok_r <= 1'b1;
      msg_r <= '0;
      sid_r <= '0;
      ya_r <= '0;
      nopt_r <= OPT_START;
      code_r <= '0;
      len_r <= '0;
      stop_r <= 1'b0;
      gather_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ok_r <= ok_nxt;
      msg_r <= msg_nxt;
      sid_r <= sid_nxt;
      ya_r <= ya_nxt;
      nopt_r <= nopt_nxt;
      code_r <= code_nxt;
      len_r <= len_nxt;
      stop_r <= stop_nxt;
      gather_r <= gather_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dhcp_res_fifo.sv =====
`default_nettype none
module dhcp_res_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire dhcp_pkg::res_t                din,
  input  wire logic                          pop,
  output dhcp_pkg::res_t                     dout,
  output logic                               valid,
  output logic [dhcp_pkg::RES_LVL_W-1:0]     level
);
  import dhcp_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, wr_nxt;
  logic [RES_PTR_W-1:0] rd_r, rd_nxt;
  logic [RES_LVL_W-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign valid = (cnt_r != '0);
  assign level = cnt_r;
  assign dout = mem_r[rd_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_r + RES_PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_r + RES_PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + RES_LVL_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - RES_LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

endmodule
`default_nettype wire

// ===== rtl/core/dhcp_client_handshake.sv =====
// DHCP client handshake controller.
// Input channel (in_valid/in_stall): one item per cycle, holding an action
// (start, timer tick or received frame byte), the frame byte and a last flag.
// Result channel (out_valid/out_stall): at most one result item per input
// item, telling the host to send a DISCOVER or a REQUEST, or reporting a
// bound address or a failed handshake, together with the addresses.
// The APB port holds the ticks per attempt window at address 0 and the
// attempt limit at address 4; write them only while the block is idle.
// An item is registered at acceptance and processed on the next edge, which
// writes its result into the result queue. Throughput is one item per cycle
// while in_stall is low; every item passes the parser and the handshake
// controller once, combinationally from its input register.
// Results wait in a three-entry queue. While the receiver stalls, items keep
// being accepted until the queue and the item in flight would fill it, and
// then in_stall rises. Nothing is dropped.
// Reset sets the window to 1000 ticks and the limit to 3 attempts, empties
// the queue and puts the controller idle with a cleared frame parser.
`default_nettype none
`include "dhcp_client_handshake_macros.svh"
module dhcp_client_handshake (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_rx_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic [31:0]      out_ip_addr,
  output logic [31:0]      out_server_addr,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dhcp_pkg::*;

  logic [31:0] ticks_r;
  logic [3:0]  max_att_r;

  logic        v1_r;
  logic [1:0]  act_r;
  logic [7:0]  byte_r;
  logic        last_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [31:0] wc_r, wc_nxt;
  logic [31:0] offered_r, offered_nxt;
  logic [31:0] server_r, server_nxt;

  logic        in_acc;
  logic        cfg_wr;
  frame_info_t info;
  logic        push;
  res_t        res;
  res_t        head;
  logic        pop;
  logic [RES_LVL_W-1:0] level;
  logic [31:0] wc_inc;
  logic [31:0] lim;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[1:0] != 2'b00) ? 32'd0 :
                  (paddr[2] ? {28'd0, max_att_r} : ticks_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
      max_att_r <= ATTEMPTS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        max_att_r <= pwdata[3:0];
      end else begin
        ticks_r <= pwdata;
      end
    end
  end

  assign in_stall = (level == RES_LVL_W'(RES_DEPTH)) ||
                    (v1_r && (level == RES_LVL_W'(RES_DEPTH - 1)));
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      byte_r <= in_rx_byte;
      last_r <= in_rx_last;
    end
  end

  dhcp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (v1_r && (act_r == ACT_BYTE)),
    .rx_byte (byte_r),
    .rx_last (last_r),
    .info    (info)
  );

  assign wc_inc = (wc_r == 32'hFFFF_FFFF) ? wc_r : wc_r + 32'd1;
  assign lim = (ticks_r == 32'd0) ? 32'd1 : ticks_r;

  always_comb begin
    phase_nxt = phase_r;
    att_nxt = att_r;
    wc_nxt = wc_r;
    offered_nxt = offered_r;
    server_nxt = server_r;
    push = 1'b0;
    res = '{event_res: EV_DISCOVER, ip_addr: 32'd0, server_addr: 32'd0};
    if (v1_r) begin
      case (act_r)
        ACT_START: begin
          phase_nxt = PH_DISC;
          att_nxt = 4'd1;
          wc_nxt = 32'd0;
          offered_nxt = 32'd0;
          server_nxt = 32'd0;
          push = 1'b1;
        end
        ACT_TICK: begin
          if (phase_r == PH_DISC || phase_r == PH_OFFER) begin
            if (wc_inc < lim) begin
              wc_nxt = wc_inc;
            end else if (att_r < max_att_r) begin
              att_nxt = att_r + 4'd1;
              wc_nxt = 32'd0;
              push = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              wc_nxt = 32'd0;
              push = 1'b1;
              res.event_res = EV_FAILED;
            end
          end
        end
        ACT_BYTE: begin
          if (info.eof && info.ok) begin
            if (info.msg_type == MSG_OFFER && phase_r == PH_DISC) begin
              offered_nxt = info.your_addr;
              server_nxt = info.server_id;
              phase_nxt = PH_OFFER;
              push = 1'b1;
              res = '{event_res: EV_REQUEST, ip_addr: info.your_addr,
                      server_addr: info.server_id};
            end else if (info.msg_type == MSG_ACK && phase_r == PH_OFFER) begin
              phase_nxt = PH_IDLE;
              wc_nxt = 32'd0;
              push = 1'b1;
              res = '{event_res: EV_BOUND, ip_addr: offered_r,
                      server_addr: server_r};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      att_r <= '0;
      wc_r <= '0;
      offered_r <= '0;
      server_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      att_r <= att_nxt;
      wc_r <= wc_nxt;
      offered_r <= offered_nxt;
      server_r <= server_nxt;
    end
  end

  assign pop = out_valid && !out_stall;

  dhcp_res_fifo u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (res),
    .pop   (pop),
    .dout  (head),
    .valid (out_valid),
    .level (level)
  );

  assign out_event_res = head.event_res;
  assign out_ip_addr = head.ip_addr;
  assign out_server_addr = head.server_addr;

  `DHCP_ASSERT_NXT(a_fail_goes_idle, clk, rst_n, push && (res.event_res == EV_FAILED), phase_r == PH_IDLE)
  `DHCP_ASSERT_IMP(a_bound_needs_offer, clk, rst_n, push && (res.event_res == EV_BOUND), phase_r == PH_OFFER)
  `DHCP_ASSERT_IMP(a_request_from_disc, clk, rst_n, push && (res.event_res == EV_REQUEST), phase_r == PH_DISC)
  `DHCP_ASSERT_IMP(a_no_overflow, clk, rst_n, push && !pop, level != RES_LVL_W'(RES_DEPTH))

endmodule
`default_nettype wire

// ===== bench/dhcp_client_handshake_tb.sv =====
module dhcp_client_handshake_tb;
  import dhcp_pkg::*;

  localparam logic [2:0] ADDR_TICKS = 3'd0;
  localparam logic [2:0] ADDR_ATTEMPTS = 3'd4;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam int POS_ETH_HI = 12;
  localparam int POS_ETH_LO = 13;
  localparam int POS_IP_PROTO = 23;
  localparam int POS_PORT_HI = 36;
  localparam int POS_PORT_LO = 37;
  localparam int POS_XID_HI = 46;
  localparam int POS_XID_LO = 47;
  localparam int POS_YIADDR = 58;
  localparam int DRAIN_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef enum int {FR_GOOD, FR_BAD_HDR, FR_SHORT, FR_CUT, FR_LONG} frame_kind_e;

  class handshake_tracker;
    logic [31:0] ticks_cfg;
    logic [3:0]  attempts_cfg;
    phase_t      hs_phase;
    logic [3:0]  attempts;
    logic [31:0] window;
    logic [31:0] held_ip;
    logic [31:0] held_server;
    logic [10:0] pos;
    logic [10:0] opt_pos;
    bit          hdr_ok;
    bit          walk_done;
    logic [7:0]  msg_kind;
    logic [7:0]  opt_code;
    logic [7:0]  opt_len;
    logic [31:0] your_ip;
    logic [31:0] server_id;
    logic [31:0] server_acc;
    res_t        pending_events[$];
    int unsigned predicted;
    int unsigned mismatches;

    function new();
      ticks_cfg = TICKS_RESET;
      attempts_cfg = ATTEMPTS_RESET;
      hs_phase = PH_IDLE;
      attempts = '0;
      window = '0;
      held_ip = '0;
      held_server = '0;
      predicted = 0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0;
      opt_pos = OPT_START;
      hdr_ok = 1'b1;
      walk_done = 1'b0;
      msg_kind = '0;
      opt_code = '0;
      opt_len = '0;
      your_ip = '0;
      server_id = '0;
      server_acc = '0;
    endfunction

    function void parse_byte(logic [7:0] b);
      int p;
      int off;
      int vi;
      p = int'(pos);
      case (p)
        POS_ETH_HI:   if (b != ETH_TYPE_HI) hdr_ok = 1'b0;
        POS_ETH_LO:   if (b != ETH_TYPE_LO) hdr_ok = 1'b0;
        POS_IP_PROTO: if (b != IP_PROTO_UDP) hdr_ok = 1'b0;
        POS_PORT_HI:  if (b != UDP_PORT_HI) hdr_ok = 1'b0;
        POS_PORT_LO:  if (b != UDP_PORT_LO) hdr_ok = 1'b0;
        POS_XID_HI:   if (b != XID_HI) hdr_ok = 1'b0;
        POS_XID_LO:   if (b != XID_LO) hdr_ok = 1'b0;
        default: ;
      endcase
      if (p >= POS_YIADDR && p <= POS_YIADDR + 3) begin
        your_ip |= 32'(b) << (8 * (p - POS_YIADDR));
      end
      if (walk_done || p < int'(opt_pos)) return;
      off = p - int'(opt_pos);
      if (off == 0) begin
        if (b == OPT_END) walk_done = 1'b1;
        else opt_code = b;
        return;
      end
      if (off == 1) begin
        opt_len = b;
        server_acc = '0;
        if (b == 8'd0) opt_pos = pos + 11'd1;
        return;
      end
      vi = off - 2;
      if (opt_code == OPT_MSG_TYPE && opt_len == 8'd1) msg_kind = b;
      if (opt_code == OPT_SERVER_ID && opt_len == 8'd4 && vi < 4) begin
        server_acc |= 32'(b) << (8 * vi);
        if (vi == 3) server_id = server_acc;
      end
      if (off == 1 + int'(opt_len)) opt_pos = pos + 11'd1;
    endfunction

    function void push_event(logic [1:0] ev, logic [31:0] ip, logic [31:0] srv);
      res_t r;
      r.event_res = ev;
      r.ip_addr = ip;
      r.server_addr = srv;
      pending_events.push_back(r);
      predicted++;
    endfunction

    function void take_item(logic [1:0] act, logic [7:0] b, logic last);
      logic [31:0] lim;
      case (act)
        ACT_START: begin
          hs_phase = PH_DISC;
          attempts = 4'd1;
          window = '0;
          held_ip = '0;
          held_server = '0;
          push_event(EV_DISCOVER, '0, '0);
        end
        ACT_TICK: begin
          if (hs_phase != PH_IDLE) begin
            if (window != '1) window++;
            lim = (ticks_cfg == '0) ? 32'd1 : ticks_cfg;
            if (window >= lim) begin
              window = '0;
              if (attempts < attempts_cfg) begin
                attempts++;
                push_event(EV_DISCOVER, '0, '0);
              end else begin
                hs_phase = PH_IDLE;
                push_event(EV_FAILED, '0, '0);
              end
            end
          end
        end
        ACT_BYTE: begin
          if (int'(pos) < MAX_FRAME) begin
            parse_byte(b);
            pos++;
          end
          if (last) begin
            if (hdr_ok && pos >= OPT_START) begin
              if (msg_kind == MSG_OFFER && hs_phase == PH_DISC) begin
                held_ip = your_ip;
                held_server = server_id;
                hs_phase = PH_OFFER;
                push_event(EV_REQUEST, held_ip, held_server);
              end else if (msg_kind == MSG_ACK && hs_phase == PH_OFFER) begin
                hs_phase = PH_IDLE;
                window = '0;
                push_event(EV_BOUND, held_ip, held_server);
              end
            end
            clear_frame();
          end
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task match_event(res_t got);
      res_t want;
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected result event %0d ip %h server %h",
                                got.event_res, got.ip_addr, got.server_addr));
        return;
      end
      want = pending_events.pop_front();
      if (got.event_res !== want.event_res)
        flag_mismatch($sformatf("event got %0d want %0d", got.event_res, want.event_res));
      if (got.ip_addr !== want.ip_addr)
        flag_mismatch($sformatf("ip_addr got %h want %h", got.ip_addr, want.ip_addr));
      if (got.server_addr !== want.server_addr)
        flag_mismatch($sformatf("server_addr got %h want %h",
                                got.server_addr, want.server_addr));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_UNUSED;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        in_rx_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_res;
  logic [31:0] out_ip_addr;
  logic [31:0] out_server_addr;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  handshake_tracker tracker;
  logic [7:0]  frame_q[$];
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;

  dhcp_client_handshake DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_rx_byte(in_rx_byte),
    .in_rx_last(in_rx_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_res(out_event_res),
    .out_ip_addr(out_ip_addr),
    .out_server_addr(out_server_addr),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.match_event({out_event_res, out_ip_addr, out_server_addr});
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(logic [1:0] act, logic [7:0] data, logic last);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_rx_byte <= data;
    in_rx_last <= last;
    do @(posedge clk); while (in_stall);
    tracker.take_item(act, data, last);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(ACT_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (tracker.pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending_events.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.pending_events.size()));
    repeat (8) @(posedge clk);
  endtask

  task automatic program_reg(logic [2:0] addr, logic [31:0] data);
    logic [31:0] want;
    want = (addr == ADDR_ATTEMPTS) ? {28'd0, data[3:0]} : data;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TICKS) tracker.ticks_cfg = data;
    else tracker.attempts_cfg = data[3:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      tracker.flag_mismatch($sformatf("register %0d reads %h want %h", addr, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push_opt(logic [7:0] code, logic [7:0] len, logic [31:0] val);
    frame_q.push_back(code);
    frame_q.push_back(len);
    for (int i = 0; i < int'(len); i++) frame_q.push_back(i < 4 ? val[8*i +: 8] : 8'($urandom));
  endfunction

  function automatic void build_frame(frame_kind_e kind, logic [7:0] mtype,
                                      logic [31:0] yip, logic [31:0] sid);
    int keep;
    int bad;
    frame_q.delete();
    for (int i = 0; i < int'(OPT_START); i++) frame_q.push_back(8'($urandom));
    frame_q[POS_ETH_HI] = ETH_TYPE_HI;
    frame_q[POS_ETH_LO] = ETH_TYPE_LO;
    frame_q[POS_IP_PROTO] = IP_PROTO_UDP;
    frame_q[POS_PORT_HI] = UDP_PORT_HI;
    frame_q[POS_PORT_LO] = UDP_PORT_LO;
    frame_q[POS_XID_HI] = XID_HI;
    frame_q[POS_XID_LO] = XID_LO;
    for (int i = 0; i < 4; i++) frame_q[POS_YIADDR + i] = yip[8*i +: 8];
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: push_opt(OPT_PAD, 8'($urandom_range(0, 3)), $urandom);
        1: push_opt(OPT_MSG_TYPE, 8'($urandom_range(0, 2)), $urandom);
        2: push_opt(OPT_SERVER_ID, 8'($urandom_range(3, 5)), $urandom);
        default: push_opt(8'($urandom_range(1, 254)), 8'($urandom_range(0, 6)), $urandom);
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      push_opt(OPT_MSG_TYPE, 8'd1, {24'd0, mtype});
      push_opt(OPT_SERVER_ID, 8'd4, sid);
    end else begin
      push_opt(OPT_SERVER_ID, 8'd4, sid);
      push_opt(OPT_MSG_TYPE, 8'd1, {24'd0, mtype});
    end
    if ($urandom_range(0, 3) != 0) begin
      frame_q.push_back(OPT_END);
      repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom));
    end
    keep = frame_q.size();
    case (kind)
      FR_BAD_HDR: begin
        case ($urandom_range(0, 6))
          0: bad = POS_ETH_HI;
          1: bad = POS_ETH_LO;
          2: bad = POS_IP_PROTO;
          3: bad = POS_PORT_HI;
          4: bad = POS_PORT_LO;
          5: bad = POS_XID_HI;
          default: bad = POS_XID_LO;
        endcase
        frame_q[bad] = frame_q[bad] ^ 8'($urandom_range(1, 255));
      end
      FR_SHORT: keep = $urandom_range(1, int'(OPT_START));
      FR_CUT: keep = $urandom_range(int'(OPT_START) + 1, frame_q.size() - 1);
      FR_LONG: begin
        keep = $urandom_range(MAX_FRAME - 2, MAX_FRAME + 60);
        while (frame_q.size() < keep) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endfunction

  task automatic send_frame(frame_kind_e kind, logic [7:0] mtype,
                            logic [31:0] yip, logic [31:0] sid);
    build_frame(kind, mtype, yip, sid);
    foreach (frame_q[i]) begin
      if ($urandom_range(0, 199) == 0) send_item(ACT_TICK, 8'($urandom), 1'($urandom));
      send_item(ACT_BYTE, frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 49);
    if (r < 40) return FR_GOOD;
    if (r < 44) return FR_BAD_HDR;
    if (r < 46) return FR_SHORT;
    if (r < 49) return FR_CUT;
    return FR_LONG;
  endfunction

  task automatic noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0: send_item(ACT_UNUSED, 8'($urandom), 1'($urandom));
        1: send_ticks(1);
        2: begin
          if ($urandom_range(0, 3) == 0) send_item(ACT_START, 8'($urandom), 1'($urandom));
          else send_item(ACT_UNUSED, 8'($urandom), 1'($urandom));
        end
        default: begin
          if ($urandom_range(0, 1) == 0) send_frame(FR_SHORT, 8'($urandom_range(0, 7)),
                                                    $urandom, $urandom);
          else send_frame(pick_kind(), 8'($urandom_range(0, 7)), $urandom, $urandom);
        end
      endcase
    end
  endtask

  task automatic run_session();
    send_item(ACT_START, 8'($urandom), 1'($urandom));
    send_ticks($urandom_range(0, 6));
    if ($urandom_range(0, 3) == 0) noise();
    send_frame(pick_kind(), MSG_OFFER, $urandom, $urandom);
    send_ticks($urandom_range(0, 6));
    if ($urandom_range(0, 3) == 0) noise();
    send_frame(pick_kind(), MSG_ACK, $urandom, $urandom);
    send_ticks($urandom_range(0, 3));
  endtask

  initial begin
    int unsigned base_results;
    int unsigned base_items;
    int ph;
    logic [31:0] ticks;
    logic [31:0] tries;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ACT_TICK, 8'h00, 1'b0);
    send_item(ACT_UNUSED, 8'hFF, 1'b1);
    send_frame(FR_GOOD, MSG_OFFER, 32'h0100_000A, 32'hFE00_000A);
    send_item(ACT_START, 8'hFF, 1'b0);
    send_frame(FR_GOOD, MSG_ACK, $urandom, $urandom);
    send_frame(FR_SHORT, MSG_OFFER, $urandom, $urandom);
    send_frame(FR_BAD_HDR, MSG_OFFER, $urandom, $urandom);
    send_frame(FR_CUT, MSG_OFFER, $urandom, $urandom);
    send_frame(FR_GOOD, MSG_OFFER, 32'h0000_0000, 32'hFFFF_FFFF);
    send_frame(FR_GOOD, MSG_OFFER, $urandom, $urandom);
    send_item(ACT_START, 8'h00, 1'b1);
    send_frame(FR_GOOD, MSG_ACK, $urandom, $urandom);
    send_frame(FR_LONG, MSG_OFFER, 32'hFFFF_FFFF, 32'h0000_0000);
    send_frame(FR_GOOD, MSG_ACK, $urandom, $urandom);
    settle();
    program_reg(ADDR_TICKS, 32'd2);
    program_reg(ADDR_ATTEMPTS, 32'd2);
    send_item(ACT_START, 8'h5A, 1'b0);
    send_ticks(5);

    base_results = tracker.predicted;
    base_items = items_sent;
    ph = 0;
    while (ph < 4 || items_sent - base_items < 1000 || tracker.predicted - base_results < 48) begin
      settle();
      case (ph)
        0: begin
          ticks = 32'd1;
          tries = 32'd15;
        end
        1: begin
          ticks = 32'hFFFF_FFFF;
          tries = 32'd0;
        end
        2: begin
          ticks = 32'd0;
          tries = 32'd1;
        end
        default: begin
          ticks = $urandom_range(1, 40);
          tries = $urandom;
        end
      endcase
      program_reg(ADDR_TICKS, ticks);
      program_reg(ADDR_ATTEMPTS, tries);
      if (ph == 3) begin
        hold_req = 1'b1;
        repeat (20) send_item(ACT_START, 8'($urandom), 1'($urandom));
      end
      repeat (2) begin
        noise();
        run_session();
      end
      ph++;
    end

    settle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    program_reg(ADDR_TICKS, 32'd6);
    program_reg(ADDR_ATTEMPTS, 32'd3);
    repeat (2) run_session();
    settle();
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== dhcp_client_handshake.f =====
+incdir+rtl/core
rtl/core/dhcp_pkg.sv
rtl/core/dhcp_parser.sv
rtl/core/dhcp_res_fifo.sv
rtl/core/dhcp_client_handshake.sv
bench/dhcp_client_handshake_tb.sv
